// File: hdl/aes128_ctr_keystream_xor_unit_macros.svh
// Assertion helpers for the counter-mode keystream unit.
// Both sample on i_clk and are switched off while i_rst_n is low.
`ifndef AES128_CTR_KEYSTREAM_XOR_UNIT_MACROS_SVH
`define AES128_CTR_KEYSTREAM_XOR_UNIT_MACROS_SVH

`define AESCTR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define AESCTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/aesctr_pkg.sv
`default_nettype none
package aesctr_pkg;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_IV_HIGH  = 2'd2;
    localparam logic [1:0] REG_IV_LOW   = 2'd3;

    localparam logic [3:0] NUM_ROUNDS = 4'd10;
    localparam logic [4:0] BLOCK_BYTES = 5'd16;

    typedef struct packed {
        logic [127:0] ctr;
        logic [127:0] data;
        logic [4:0]   vb;
    } t_job;

    typedef struct packed {
        logic busy;
        logic finish;
    } t_eng_stat;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] rnd);
        logic [7:0] r;
        case (rnd)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w3;
        logic [31:0] tmp;
        logic [31:0] n0;
        logic [31:0] n1;
        logic [31:0] n2;
        logic [31:0] n3;
        w3  = k[31:0];
        tmp = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        n0  = k[127:96] ^ tmp;
        n1  = k[95:64] ^ n0;
        n2  = k[63:32] ^ n1;
        n3  = w3 ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0]   t [16];
        logic [7:0]   u [16];
        logic [7:0]   a0;
        logic [7:0]   a1;
        logic [7:0]   a2;
        logic [7:0]   a3;
        logic [7:0]   all;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            t[i] = SBOX[s[127-8*i -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int rr = 0; rr < 4; rr++) begin
                u[4*c+rr] = t[4*((c+rr)%4)+rr];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0  = u[4*c];
                a1  = u[4*c+1];
                a2  = u[4*c+2];
                a3  = u[4*c+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                u[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
                u[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
                u[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
                u[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127-8*i -: 8] = u[i];
        end
        return r;
    endfunction

    function automatic logic [127:0] byte_mask(input logic [4:0] vb);
        logic [127:0] m;
        for (int i = 0; i < 16; i++) begin
            m[127-8*i -: 8] = (5'(i) < vb) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// File: hdl/aesctr_front.sv
`default_nettype none
module aesctr_front
    import aesctr_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  wire logic         i_first_block,
    input  wire logic [63:0]  i_data_high,
    input  wire logic [63:0]  i_data_low,
    input  wire logic [4:0]   i_valid_bytes,
    input  wire logic [127:0] i_iv,
    output t_job              o_job
);

    logic [127:0] r_ctr;
    logic [127:0] n_ctr;
    logic [127:0] w_ctr_use;

    assign w_ctr_use = i_first_block ? i_iv : r_ctr;
    assign n_ctr     = w_ctr_use + 128'd1;

    always_comb begin
        o_job.ctr  = w_ctr_use;
        o_job.data = {i_data_high, i_data_low};
        o_job.vb   = (i_valid_bytes > BLOCK_BYTES) ? BLOCK_BYTES : i_valid_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0;
        end else if (i_accept) begin
            r_ctr <= n_ctr;
        end
    end

endmodule
`default_nettype wire

// File: hdl/aesctr_queue.sv
`default_nettype none
module aesctr_queue
    import aesctr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  t_job      i_wdata,
    input  wire logic i_rd,
    output t_job      o_rdata,
    output logic      o_full,
    output logic      o_empty
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            case ({i_wr, i_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hdl/aesctr_engine.sv
`default_nettype none
module aesctr_engine
    import aesctr_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic [127:0] i_key,
    input  t_job              i_job,
    input  wire logic         i_q_empty,
    output logic              o_q_pop,
    input  wire logic         i_pop,
    output logic              o_empty,
    output logic [63:0]       o_result_high,
    output logic [63:0]       o_result_low,
    output logic [4:0]        o_result_bytes,
    output t_eng_stat         o_stat
);

    logic         r_busy;
    logic [3:0]   r_rnd;
    logic [127:0] r_state;
    logic [127:0] r_rk;
    logic [127:0] r_data;
    logic [4:0]   r_vb;
    logic         r_ov;
    logic [127:0] r_res;
    logic [4:0]   r_res_vb;

    logic [3:0]   n_rnd;
    logic [127:0] n_rk;
    logic         w_done;
    logic         w_finish;
    logic         w_load;

    assign n_rnd    = r_rnd + 4'd1;
    assign n_rk     = key_step(r_rk, rcon(n_rnd));
    assign w_done   = r_busy && (r_rnd == NUM_ROUNDS);
    assign w_finish = w_done && (!r_ov || i_pop);
    assign w_load   = !i_q_empty && (!r_busy || w_finish);

    assign o_q_pop        = w_load;
    assign o_empty        = !r_ov;
    assign o_result_high  = r_res[127:64];
    assign o_result_low   = r_res[63:0];
    assign o_result_bytes = r_res_vb;
    assign o_stat.busy    = r_busy;
    assign o_stat.finish  = w_finish;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rnd   <= '0;
            r_state <= i_job.ctr ^ i_key;
            r_rk    <= i_key;
            r_data  <= i_job.data;
            r_vb    <= i_job.vb;
        end else if (r_busy && !w_done) begin
            r_rnd   <= n_rnd;
            r_rk    <= n_rk;
            r_state <= aes_round(r_state, n_rnd == NUM_ROUNDS) ^ n_rk;
        end
        if (w_finish) begin
            r_res    <= (r_data ^ r_state) & byte_mask(r_vb);
            r_res_vb <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
            end else if (w_finish) begin
                r_busy <= 1'b0;
            end
            if (w_finish) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/aes128_ctr_keystream_xor_unit.sv
// AES-128 counter-mode unit: each pushed 16-byte block is XORed with the
// encryption of a 128-bit big-endian counter and comes out on the result side
// with bytes past the valid count cleared. A block marked first reloads the
// counter from the IV registers; the counter steps by one after every block.
// The front assigns counters and feeds a two-entry queue; the engine runs one
// AES round per cycle with the key schedule computed alongside, and takes the
// next block from the queue only as it finishes the current one. With the
// engine idle, a block passes through the queue, the engine's state register
// over its rounds and the output register before its result is ready. A
// finished result waits in an output register while the next block is already
// being encrypted. Write the key and IV registers only while idle.
`default_nettype none
`include "aes128_ctr_keystream_xor_unit_macros.svh"
module aes128_ctr_keystream_xor_unit
    import aesctr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_first_block,
    input  wire logic [63:0] i_data_high,
    input  wire logic [63:0] i_data_low,
    input  wire logic [4:0]  i_valid_bytes,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      o_result_high,
    output logic [63:0]      o_result_low,
    output logic [4:0]       o_result_bytes
);

    logic [63:0] r_key_high;
    logic [63:0] r_key_low;
    logic [63:0] r_iv_high;
    logic [63:0] r_iv_low;

    t_job      w_job;
    t_job      w_q_job;
    t_eng_stat w_stat;
    logic      w_accept;
    logic      w_q_pop;
    logic      w_q_empty;

    assign w_accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_iv_high  <= '0;
            r_iv_low   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                REG_IV_HIGH:  r_iv_high  <= i_cfg_data;
                REG_IV_LOW:   r_iv_low   <= i_cfg_data;
                default:      r_iv_low   <= r_iv_low;
            endcase
        end
    end

    aesctr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_first_block (i_first_block),
        .i_data_high   (i_data_high),
        .i_data_low    (i_data_low),
        .i_valid_bytes (i_valid_bytes),
        .i_iv          ({r_iv_high, r_iv_low}),
        .o_job         (w_job)
    );

    aesctr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_accept),
        .i_wdata (w_job),
        .i_rd    (w_q_pop),
        .o_rdata (w_q_job),
        .o_full  (full),
        .o_empty (w_q_empty)
    );

    aesctr_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_key          ({r_key_high, r_key_low}),
        .i_job          (w_q_job),
        .i_q_empty      (w_q_empty),
        .o_q_pop        (w_q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_result_high  (o_result_high),
        .o_result_low   (o_result_low),
        .o_result_bytes (o_result_bytes),
        .o_stat         (w_stat)
    );

    `AESCTR_ASSERT_NEXT(a_finish_shows_result, w_stat.finish, !empty, "Result not shown.")
    `AESCTR_ASSERT_NEXT(a_push_reaches_queue, w_accept, !w_q_empty, "Block not queued.")
    `AESCTR_ASSERT_NEXT(a_idle_engine_starts, !w_stat.busy && !w_q_empty, w_stat.busy, "No start.")
    `AESCTR_ASSERT_NOW(a_pop_only_when_queued, w_q_pop, !w_q_empty, "Pop from empty queue.")

endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
module tb;
    import aesctr_pkg::*;

    typedef struct {
        logic [63:0] high;
        logic [63:0] low;
        logic [4:0]  nbytes;
    } t_block_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = REG_KEY_HIGH;
    logic [63:0] i_cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic        i_first_block = 1'b0;
    logic [63:0] i_data_high = '0;
    logic [63:0] i_data_low = '0;
    logic [4:0]  i_valid_bytes = 5'd16;
    logic        empty;
    logic        pop = 1'b0;
    logic [63:0] o_result_high;
    logic [63:0] o_result_low;
    logic [4:0]  o_result_bytes;

    logic [7:0]   sub_tab [256];
    logic [127:0] cipher_key;
    logic [127:0] iv_value;
    logic [127:0] ctr_value;
    t_block_out   pending_blocks [$];
    int           error_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;

    aes128_ctr_keystream_xor_unit i_dut (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [7:0] gf_dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = gf_dbl(a);
        end
        return acc;
    endfunction

    function automatic logic [7:0] rot8(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    task automatic build_sub_tab();
        logic [7:0] inv;
        logic [7:0] base;
        for (int i = 0; i < 256; i++) begin
            inv = 8'h01;
            base = 8'(i);
            for (int e = 254; e != 0; e >>= 1) begin
                if (e & 1) inv = gf_mul(inv, base);
                base = gf_mul(base, base);
            end
            if (i == 0) inv = 8'h00;
            sub_tab[i] = inv ^ rot8(inv, 1) ^ rot8(inv, 2) ^ rot8(inv, 3) ^ rot8(inv, 4)
                         ^ 8'h63;
        end
    endtask

    function automatic logic [127:0] aes_encrypt(input logic [127:0] blk,
                                                 input logic [127:0] key);
        logic [127:0] rk;
        logic [127:0] st;
        logic [7:0]   t [16];
        logic [7:0]   u [16];
        logic [7:0]   rc;
        logic [7:0]   a0, a1, a2, a3, sum;
        logic [31:0]  w;
        rk = key;
        st = blk ^ rk;
        rc = 8'h01;
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int i = 0; i < 16; i++) t[i] = sub_tab[st[127-8*i -: 8]];
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++) u[4*c+r] = t[4*((c+r)%4)+r];
            if (rnd != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
                    sum = a0 ^ a1 ^ a2 ^ a3;
                    u[4*c]   = a0 ^ sum ^ gf_dbl(a0 ^ a1);
                    u[4*c+1] = a1 ^ sum ^ gf_dbl(a1 ^ a2);
                    u[4*c+2] = a2 ^ sum ^ gf_dbl(a2 ^ a3);
                    u[4*c+3] = a3 ^ sum ^ gf_dbl(a3 ^ a0);
                end
            end
            w = {sub_tab[rk[23:16]] ^ rc, sub_tab[rk[15:8]], sub_tab[rk[7:0]],
                 sub_tab[rk[31:24]]};
            rk[127:96] ^= w;
            rk[95:64]  ^= rk[127:96];
            rk[63:32]  ^= rk[95:64];
            rk[31:0]   ^= rk[63:32];
            rc = gf_dbl(rc);
            for (int i = 0; i < 16; i++) st[127-8*i -: 8] = u[i];
            st ^= rk;
        end
        return st;
    endfunction

    function automatic t_block_out predict_block(input logic first, input logic [127:0] data,
                                                 input logic [4:0] count);
        t_block_out   res;
        logic [127:0] ks;
        logic [127:0] out;
        int           n;
        if (first) ctr_value = iv_value;
        n = (count > 5'd16) ? 16 : int'(count);
        ks = aes_encrypt(ctr_value, cipher_key) ^ data;
        out = '0;
        for (int i = 0; i < n; i++) out[127-8*i -: 8] = ks[127-8*i -: 8];
        ctr_value = ctr_value + 128'd1;
        res.high = out[127:64];
        res.low = out[63:0];
        res.nbytes = 5'(n);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_block_out want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_blocks.size() == 0) begin
                    $error("unexpected result high=%h low=%h", o_result_high, o_result_low);
                    error_count++;
                end else begin
                    want = pending_blocks.pop_front();
                    if (o_result_high !== want.high) begin
                        $error("result_high expected %h actual %h", want.high, o_result_high);
                        error_count++;
                    end
                    if (o_result_low !== want.low) begin
                        $error("result_low expected %h actual %h", want.low, o_result_low);
                        error_count++;
                    end
                    if (o_result_bytes !== want.nbytes) begin
                        $error("result_bytes expected %0d actual %0d", want.nbytes,
                               o_result_bytes);
                        error_count++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_block(input logic first, input logic [63:0] hi, input logic [63:0] lo,
                              input logic [4:0] count);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_first_block <= first;
        i_data_high <= hi;
        i_data_low <= lo;
        i_valid_bytes <= count;
        do @(posedge i_clk); while (full);
        pending_blocks.push_back(predict_block(first, {hi, lo}, count));
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_KEY_HIGH: cipher_key[127:64] = value;
            REG_KEY_LOW:  cipher_key[63:0] = value;
            REG_IV_HIGH:  iv_value[127:64] = value;
            REG_IV_LOW:   iv_value[63:0] = value;
            default:      iv_value = iv_value;
        endcase
    endtask

    task automatic load_all(input logic [127:0] key, input logic [127:0] iv);
        drain();
        write_reg(REG_KEY_HIGH, key[127:64]);
        write_reg(REG_KEY_LOW, key[63:0]);
        write_reg(REG_IV_HIGH, iv[127:64]);
        write_reg(REG_IV_LOW, iv[63:0]);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_after_reset();
        send_block(1'b0, '0, '0, 5'd16);
        send_block(1'b0, '1, '1, 5'd16);
        send_block(1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd16);
    endtask

    task automatic test_byte_counts();
        load_all({rand64(), rand64()}, {rand64(), rand64()});
        send_block(1'b1, '1, '1, 5'd0);
        for (int n = 1; n <= 16; n += 3) send_block(1'b0, '1, '1, 5'(n));
        send_block(1'b0, '1, '1, 5'd16);
        send_block(1'b0, '1, '1, 5'd17);
        send_block(1'b0, rand64(), rand64(), 5'd31);
    endtask

    task automatic test_counter_wrap();
        load_all('1, '1);
        send_block(1'b1, '0, '0, 5'd16);
        send_block(1'b0, '1, '1, 5'd16);
        load_all('0, {64'd0, 64'hffff_ffff_ffff_fffe});
        send_block(1'b1, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 5'd16);
        send_block(1'b0, '0, '0, 5'd16);
        send_block(1'b0, '0, '0, 5'd8);
    endtask

    task automatic test_random_traffic(input int items, input int s_idle, input int r_idle);
        int sent;
        int msg_len;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(9) == 0)
                load_all({rand64(), rand64()}, {rand64(), rand64()});
            msg_len = $urandom_range(1, 8);
            for (int k = 0; k < msg_len; k++) begin
                if ($urandom_range(9) == 0)
                    send_block(1'($urandom_range(1)), rand64(), rand64(),
                               5'($urandom_range(31)));
                else
                    send_block(k == 0, rand64(), rand64(),
                               (k == msg_len - 1) ? 5'($urandom_range(1, 16)) : 5'd16);
                sent++;
            end
        end
    endtask

    initial begin
        build_sub_tab();
        cipher_key = '0;
        iv_value = '0;
        ctr_value = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_after_reset();
        test_byte_counts();
        test_counter_wrap();
        test_random_traffic(230, 11, 72);
        test_random_traffic(230, 72, 11);
        test_random_traffic(240, 0, 0);
        drain();
        if (error_count == 0 && pending_blocks.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
